>>> hw/rtl/uraf_pkg.sv
// types and constants shared by the register access framer and its checker
package uraf_pkg;

	typedef enum logic [1:0] {
		OP_READ    = 2'd0,
		OP_WRITE   = 2'd1,
		OP_PAYLOAD = 2'd2,
		OP_RX      = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		KIND_TX   = 2'd0,
		KIND_DATA = 2'd1,
		KIND_DONE = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		PH_IDLE      = 3'd0,
		PH_PAYLOAD   = 3'd1,
		PH_RX_FIRST  = 3'd2,
		PH_RX_LEN    = 3'd3,
		PH_RX_DATA   = 3'd4,
		PH_RX_STATUS = 3'd5,
		PH_W_SECOND  = 3'd6
	} phase_t;

	typedef struct packed {
		op_t        operation;
		logic [7:0] reg_addr;
		logic [7:0] length;
		logic [7:0] data_byte;
	} req_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] byte_value;
		logic [7:0] result_code;
		logic       last;
	} rsp_t;

	localparam logic [7:0] SYNC_TX   = 8'haa;
	localparam logic [7:0] CMD_READ  = 8'h01;
	localparam logic [7:0] CMD_WRITE = 8'h00;
	localparam logic [7:0] ACK_READ  = 8'hbb;
	localparam logic [7:0] ACK_STAT  = 8'hee;
	localparam logic [7:0] STAT_OK   = 8'h01;
	localparam logic [7:0] CODE_OK   = 8'h00;
	localparam logic [7:0] CODE_BAD  = 8'hff;

	localparam int unsigned MAX_RES = 4;

endpackage

>>> hw/rtl/uart_register_access_framer_unit.sv
// register access framer: request framing, reply parsing and result buffering
//
// Every accepted item is decoded in the cycle it is taken and its results (up to four)
// are written into a four-entry result buffer, which feeds an output register one
// result per cycle while the output is not stalled. A read or write request gives four
// results, a payload byte one, a received byte none to two. A new item is
// taken as soon as the buffer is empty or hands over its last entry, even while the
// output register still holds a result that has not been taken. Requests that arrive
// while a transaction is open, and received bytes while idle, produce no results.
module uart_register_access_framer_unit
	import uraf_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	phase_t     phase_q, phase_d;
	logic       is_write_q, is_write_d;
	logic [7:0] exp_len_q, exp_len_d;
	logic [7:0] byte_cnt_q, byte_cnt_d;
	logic [7:0] first_reply_q, first_reply_d;

	rsp_t       res_d [MAX_RES];
	logic [2:0] res_n;
	rsp_t       buf_q [MAX_RES];
	logic [2:0] rem_q;
	logic [1:0] idx_q;

	logic       accept;
	logic       move;
	logic [7:0] cnt_inc;

	function automatic rsp_t mk(kind_t k, logic [7:0] v, logic [7:0] c);
		rsp_t r;
		r.kind        = k;
		r.byte_value  = v;
		r.result_code = c;
		r.last        = 1'b0;
		return r;
	endfunction

	assign move      = (rem_q != 3'd0) && (!rsp_valid || !rsp_stall);
	assign req_stall = !((rem_q == 3'd0) || (rem_q == 3'd1 && move));
	assign accept    = req_valid && !req_stall;
	assign cnt_inc   = byte_cnt_q + 8'd1;

	always_comb begin
		phase_d       = phase_q;
		is_write_d    = is_write_q;
		exp_len_d     = exp_len_q;
		byte_cnt_d    = byte_cnt_q;
		first_reply_d = first_reply_q;
		res_n         = 3'd0;
		for (int i = 0; i < MAX_RES; i++) begin
			res_d[i] = mk(KIND_TX, 8'd0, 8'd0);
		end
		unique case (req.operation)
			OP_READ, OP_WRITE: begin
				if (phase_q == PH_IDLE) begin
					is_write_d = (req.operation == OP_WRITE);
					exp_len_d  = req.length;
					byte_cnt_d = 8'd0;
					res_d[0]   = mk(KIND_TX, SYNC_TX, 8'd0);
					res_d[1]   = mk(KIND_TX, (req.operation == OP_WRITE) ? CMD_WRITE : CMD_READ,
						8'd0);
					res_d[2]   = mk(KIND_TX, req.reg_addr, 8'd0);
					res_d[3]   = mk(KIND_TX, req.length, 8'd0);
					res_n      = 3'd4;
					if (req.operation == OP_WRITE && req.length != 8'd0) begin
						phase_d = PH_PAYLOAD;
					end else begin
						phase_d = PH_RX_FIRST;
					end
				end
			end
			OP_PAYLOAD: begin
				if (phase_q == PH_PAYLOAD) begin
					res_d[0]   = mk(KIND_TX, req.data_byte, 8'd0);
					res_n      = 3'd1;
					byte_cnt_d = cnt_inc;
					if (cnt_inc == exp_len_q) begin
						phase_d = PH_RX_FIRST;
					end
				end
			end
			OP_RX: begin
				unique case (phase_q)
					PH_RX_FIRST: begin
						priority if (is_write_q) begin
							first_reply_d = req.data_byte;
							phase_d       = PH_W_SECOND;
						end else if (req.data_byte == ACK_READ) begin
							phase_d = PH_RX_LEN;
						end else if (req.data_byte == ACK_STAT) begin
							phase_d = PH_RX_STATUS;
						end else begin
							res_d[0] = mk(KIND_DONE, 8'd0, CODE_BAD);
							res_n    = 3'd1;
							phase_d  = PH_IDLE;
						end
					end
					PH_RX_LEN: begin
						priority if (req.data_byte != exp_len_q) begin
							res_d[0] = mk(KIND_DONE, 8'd0, CODE_BAD);
							res_n    = 3'd1;
							phase_d  = PH_IDLE;
						end else if (exp_len_q == 8'd0) begin
							res_d[0] = mk(KIND_DONE, 8'd0, CODE_OK);
							res_n    = 3'd1;
							phase_d  = PH_IDLE;
						end else begin
							byte_cnt_d = 8'd0;
							phase_d    = PH_RX_DATA;
						end
					end
					PH_RX_DATA: begin
						res_d[0]   = mk(KIND_DATA, req.data_byte, 8'd0);
						res_n      = 3'd1;
						byte_cnt_d = cnt_inc;
						if (cnt_inc == exp_len_q) begin
							res_d[1] = mk(KIND_DONE, 8'd0, CODE_OK);
							res_n    = 3'd2;
							phase_d  = PH_IDLE;
						end
					end
					PH_RX_STATUS: begin
						res_d[0] = mk(KIND_DONE, 8'd0, req.data_byte);
						res_n    = 3'd1;
						phase_d  = PH_IDLE;
					end
					PH_W_SECOND: begin
						if (first_reply_q != ACK_STAT) begin
							res_d[0] = mk(KIND_DONE, 8'd0, CODE_BAD);
						end else if (req.data_byte == STAT_OK) begin
							res_d[0] = mk(KIND_DONE, 8'd0, CODE_OK);
						end else begin
							res_d[0] = mk(KIND_DONE, 8'd0, req.data_byte);
						end
						res_n   = 3'd1;
						phase_d = PH_IDLE;
					end
					default: begin
					end
				endcase
			end
			default: begin
			end
		endcase
		for (int i = 0; i < MAX_RES; i++) begin
			res_d[i].last = ((3'(i) + 3'd1) == res_n);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_IDLE;
			is_write_q    <= 1'b0;
			exp_len_q     <= 8'd0;
			byte_cnt_q    <= 8'd0;
			first_reply_q <= 8'd0;
		end else if (accept) begin
			phase_q       <= phase_d;
			is_write_q    <= is_write_d;
			exp_len_q     <= exp_len_d;
			byte_cnt_q    <= byte_cnt_d;
			first_reply_q <= first_reply_d;
		end
	end

	// result buffer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= 3'd0;
			idx_q <= 2'd0;
		end else if (accept) begin
			rem_q <= res_n;
			idx_q <= 2'd0;
		end else if (move) begin
			rem_q <= rem_q - 3'd1;
			idx_q <= idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			buf_q <= res_d;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid <= 1'b0;
		end else if (move) begin
			rsp_valid <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (move) begin
			rsp <= buf_q[idx_q];
		end
	end

endmodule

>>> hw/rtl/uraf_checker.sv
// port-level checks for the register access framer, bound to the top level
module uraf_checker
	import uraf_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_stall,
	input req_t req,
	input logic rsp_valid,
	input logic rsp_stall,
	input rsp_t rsp
);

	// a stalled result holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("result changed while stalled");

	// a completion ends the results of its transaction
	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.kind == KIND_DONE |-> rsp.last)
		else $error("completion not marked last");

	a_done_byte: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.kind == KIND_DONE |-> rsp.byte_value == 8'd0)
		else $error("completion carries a byte value");

	a_code_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.kind != KIND_DONE |-> rsp.result_code == 8'd0)
		else $error("byte result carries a code");

endmodule

bind uart_register_access_framer_unit uraf_checker u_uraf_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.req       (req),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);

>>> sim/uart_register_access_framer_unit_tb.sv
// testbench for the register access framer: framing, reply parsing and result order
module uart_register_access_framer_unit_tb
	import uraf_pkg::*;
;

	class link_scoreboard;
		phase_t     phase = PH_IDLE;
		bit         is_write = 1'b0;
		logic [7:0] expected_len = 8'h00;
		logic [7:0] byte_count = 8'h00;
		logic [7:0] first_reply = 8'h00;
		rsp_t       due[$];
		rsp_t       batch[$];
		int         mismatches = 0;

		function void add(kind_t k, logic [7:0] v, logic [7:0] c);
			rsp_t e;
			e.kind = k;
			e.byte_value = v;
			e.result_code = c;
			e.last = 1'b0;
			batch.push_back(e);
		endfunction

		function void close(logic [7:0] c);
			add(KIND_DONE, 8'h00, c);
			phase = PH_IDLE;
		endfunction

		// works out the frames caused by one accepted transaction, 0 when it is ignored
		function bit predict_frames(req_t r);
			bit   used;
			rsp_t tail;
			used = 1'b1;
			batch.delete();
			case (r.operation)
				OP_READ, OP_WRITE: begin
					if (phase != PH_IDLE) begin
						used = 1'b0;
					end else begin
						is_write = (r.operation == OP_WRITE);
						expected_len = r.length;
						byte_count = 8'h00;
						add(KIND_TX, SYNC_TX, CODE_OK);
						add(KIND_TX, is_write ? CMD_WRITE : CMD_READ, CODE_OK);
						add(KIND_TX, r.reg_addr, CODE_OK);
						add(KIND_TX, r.length, CODE_OK);
						phase = (is_write && r.length != 8'h00) ? PH_PAYLOAD : PH_RX_FIRST;
					end
				end
				OP_PAYLOAD: begin
					if (phase != PH_PAYLOAD) begin
						used = 1'b0;
					end else begin
						add(KIND_TX, r.data_byte, CODE_OK);
						byte_count = byte_count + 8'd1;
						if (byte_count == expected_len)
							phase = PH_RX_FIRST;
					end
				end
				default: begin
					case (phase)
						PH_RX_FIRST: begin
							if (is_write) begin
								first_reply = r.data_byte;
								phase = PH_W_SECOND;
							end else if (r.data_byte == ACK_READ) begin
								phase = PH_RX_LEN;
							end else if (r.data_byte == ACK_STAT) begin
								phase = PH_RX_STATUS;
							end else begin
								close(CODE_BAD);
							end
						end
						PH_RX_LEN: begin
							if (r.data_byte != expected_len) begin
								close(CODE_BAD);
							end else if (expected_len == 8'h00) begin
								close(CODE_OK);
							end else begin
								byte_count = 8'h00;
								phase = PH_RX_DATA;
							end
						end
						PH_RX_DATA: begin
							add(KIND_DATA, r.data_byte, CODE_OK);
							byte_count = byte_count + 8'd1;
							if (byte_count == expected_len)
								close(CODE_OK);
						end
						PH_RX_STATUS: close(r.data_byte);
						PH_W_SECOND: begin
							if (first_reply != ACK_STAT)
								close(CODE_BAD);
							else
								close(r.data_byte == STAT_OK ? CODE_OK : r.data_byte);
						end
						default: used = 1'b0;
					endcase
				end
			endcase
			if (batch.size() > 0) begin
				tail = batch.pop_back();
				tail.last = 1'b1;
				batch.push_back(tail);
			end
			foreach (batch[i])
				due.push_back(batch[i]);
			return used;
		endfunction

		function void compare_field(string name, int e, int a);
			if (e != a) begin
				$display("%0t: %s expected %0h actual %0h", $time, name, e, a);
				mismatches++;
			end
		endfunction

		function void check_frame(rsp_t got);
			rsp_t e;
			if (due.size() == 0) begin
				$display("%0t: unexpected result, expected none actual %h", $time, got);
				mismatches++;
				return;
			end
			e = due.pop_front();
			compare_field("kind", e.kind, got.kind);
			compare_field("byte_value", e.byte_value, got.byte_value);
			compare_field("result_code", e.result_code, got.result_code);
			compare_field("last", e.last, got.last);
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	req_t req;
	logic rsp_valid;
	logic rsp_stall;
	rsp_t rsp;

	link_scoreboard sb = new();
	int  tx_idle = 33;
	int  rx_idle = 86;
	int  n_done = 0;
	int  hold_left;
	bit  hold_trigger = 1'b0;

	uart_register_access_framer_unit u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic logic [7:0] rbyte();
		return 8'($urandom);
	endfunction

	function automatic logic [7:0] pick_len();
		return 8'($urandom_range(0, 6));
	endfunction

	task automatic offer(op_t op, logic [7:0] reg_a, logic [7:0] len, logic [7:0] b);
		req_t r;
		r.operation = op;
		r.reg_addr = reg_a;
		r.length = len;
		r.data_byte = b;
		while ($urandom_range(99) < tx_idle) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req <= r;
		do @(posedge clk); while (req_stall);
		if (sb.predict_frames(r))
			n_done++;
	endtask

	// finish whatever transaction is still open so the next request is taken
	task automatic drain();
		while (sb.phase != PH_IDLE) begin
			if (sb.phase == PH_PAYLOAD)
				offer(OP_PAYLOAD, rbyte(), rbyte(), rbyte());
			else
				offer(OP_RX, rbyte(), rbyte(), rbyte());
		end
	endtask

	task automatic read_sequence();
		logic [7:0] len;
		int         style;
		int         i;
		len = pick_len();
		style = $urandom_range(99);
		offer(OP_READ, rbyte(), len, rbyte());
		if ($urandom_range(7) == 0)
			offer(op_t'($urandom_range(0, 2)), rbyte(), rbyte(), rbyte());
		if (style < 70) begin
			offer(OP_RX, rbyte(), rbyte(), ACK_READ);
			if ($urandom_range(9) == 0) begin
				offer(OP_RX, rbyte(), rbyte(), len ^ 8'($urandom_range(1, 255)));
			end else begin
				offer(OP_RX, rbyte(), rbyte(), len);
				for (i = 0; i < len; i++)
					offer(OP_RX, rbyte(), rbyte(), rbyte());
			end
		end else if (style < 85) begin
			offer(OP_RX, rbyte(), rbyte(), ACK_STAT);
			offer(OP_RX, rbyte(), rbyte(), rbyte());
		end else begin
			offer(OP_RX, rbyte(), rbyte(), rbyte());
		end
		drain();
	endtask

	task automatic write_sequence();
		logic [7:0] len;
		int         style;
		int         i;
		len = pick_len();
		style = $urandom_range(99);
		offer(OP_WRITE, rbyte(), len, rbyte());
		if (style < 95) begin
			for (i = 0; i < len; i++) begin
				if ($urandom_range(15) == 0)
					offer(OP_RX, rbyte(), rbyte(), rbyte());
				if ($urandom_range(15) == 0)
					offer(op_t'($urandom_range(0, 1)), rbyte(), rbyte(), rbyte());
				offer(OP_PAYLOAD, rbyte(), rbyte(), rbyte());
			end
			if (style < 60) begin
				offer(OP_RX, rbyte(), rbyte(), ACK_STAT);
				offer(OP_RX, rbyte(), rbyte(), STAT_OK);
			end else if (style < 80) begin
				offer(OP_RX, rbyte(), rbyte(), ACK_STAT);
				offer(OP_RX, rbyte(), rbyte(), rbyte());
			end else begin
				offer(OP_RX, rbyte(), rbyte(), rbyte());
				offer(OP_RX, rbyte(), rbyte(), rbyte());
			end
		end
		drain();
	endtask

	task automatic random_phase(int n);
		int stop;
		int pick;
		stop = n_done + n;
		while (n_done < stop) begin
			pick = $urandom_range(9);
			if (pick == 0) begin
				offer(op_t'($urandom_range(0, 3)), rbyte(), rbyte(), rbyte());
				drain();
			end else if (pick < 5) begin
				read_sequence();
			end else begin
				write_sequence();
			end
		end
	endtask

	// result side: check every accepted result, stall at random or for a long hold-off
	initial begin
		rsp_stall = 1'b0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (rsp_valid && !rsp_stall)
				sb.check_frame(rsp);
			if (hold_trigger) begin
				hold_left = 300;
				hold_trigger = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_stall <= 1'b1;
			end else begin
				rsp_stall <= ($urandom_range(99) < rx_idle);
			end
		end
	end

	initial begin
		int i;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// ignored while idle
		offer(OP_RX, 8'h00, 8'h00, 8'hff);
		offer(OP_PAYLOAD, 8'hff, 8'hff, 8'h00);
		// zero length read and write
		offer(OP_READ, 8'h00, 8'h00, 8'h00);
		offer(OP_RX, 8'h00, 8'h00, ACK_READ);
		offer(OP_RX, 8'h00, 8'h00, 8'h00);
		offer(OP_WRITE, 8'hff, 8'h00, 8'hff);
		offer(OP_RX, 8'h00, 8'h00, ACK_STAT);
		offer(OP_RX, 8'h00, 8'h00, STAT_OK);
		// read of one byte with a request while busy
		offer(OP_READ, 8'h5a, 8'h01, 8'h00);
		offer(OP_WRITE, 8'h11, 8'h03, 8'h22);
		offer(OP_RX, 8'h00, 8'h00, ACK_READ);
		offer(OP_RX, 8'h00, 8'h00, 8'h01);
		offer(OP_RX, 8'h00, 8'h00, 8'hff);
		// malformed first reply byte
		offer(OP_READ, 8'h33, 8'h02, 8'h00);
		offer(OP_RX, 8'h00, 8'h00, 8'h00);
		// length echo mismatch at the largest length
		offer(OP_READ, 8'hc3, 8'hff, 8'h00);
		offer(OP_RX, 8'h00, 8'h00, ACK_READ);
		offer(OP_RX, 8'h00, 8'h00, 8'hfe);
		// status reply to a read
		offer(OP_READ, 8'h01, 8'h04, 8'h00);
		offer(OP_RX, 8'h00, 8'h00, ACK_STAT);
		offer(OP_RX, 8'h00, 8'h00, 8'h7f);
		// received byte while payload is awaited, then a failing status
		offer(OP_WRITE, 8'h80, 8'h01, 8'h00);
		offer(OP_RX, 8'h00, 8'h00, ACK_STAT);
		offer(OP_PAYLOAD, 8'h00, 8'h00, 8'h80);
		offer(OP_RX, 8'h00, 8'h00, ACK_STAT);
		offer(OP_RX, 8'h00, 8'h00, 8'h05);
		// write reply not starting with the status marker
		offer(OP_WRITE, 8'h7e, 8'h01, 8'h00);
		offer(OP_PAYLOAD, 8'h00, 8'h00, 8'h01);
		offer(OP_RX, 8'h00, 8'h00, 8'h12);
		offer(OP_RX, 8'h00, 8'h00, 8'h34);
		drain();

		random_phase(35);
		tx_idle = 86;
		rx_idle = 33;
		random_phase(35);
		tx_idle = 0;
		rx_idle = 0;

		// long receiver hold-off while a read reply keeps coming
		hold_trigger = 1'b1;
		offer(OP_READ, rbyte(), 8'd12, rbyte());
		offer(OP_RX, rbyte(), rbyte(), ACK_READ);
		offer(OP_RX, rbyte(), rbyte(), 8'd12);
		for (i = 0; i < 12; i++)
			offer(OP_RX, rbyte(), rbyte(), rbyte());
		drain();
		random_phase(35);

		req_valid <= 1'b0;
		while (sb.due.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (sb.mismatches == 0)
			$display("uart_register_access_framer_unit_tb OK");
		else
			$display("uart_register_access_framer_unit_tb NOT OK");
		$finish;
	end

	initial begin
		#5000000;
		$display("uart_register_access_framer_unit_tb NOT OK");
		$finish;
	end

endmodule
